@@ hdl/directional_nearest_point_search_top_defines.svh @@
// directional_nearest_point_search_top_defines.svh
// concurrent assertion macros for the nearest point search rtl
// no dependencies; define SYNTH to drop every check
`ifndef DIRECTIONAL_NEAREST_POINT_SEARCH_TOP_DEFINES_SVH
`define DIRECTIONAL_NEAREST_POINT_SEARCH_TOP_DEFINES_SVH
`ifndef SYNTH
// plain property, checked outside reset
`define DNPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// same-cycle implication
`define DNPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DNPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DNPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DNPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DNPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/dnps_pkg.sv @@
// dnps_pkg.sv
// shared constants, codes and types of the nearest point search
// no dependencies
`timescale 1ns / 1ps

package dnps_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF  = 16;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int IN_COORD_W = 16;
    localparam int START_W   = 10;
    localparam int DIR_W     = 2;
    localparam int IDX_OUT_W = 10;
    localparam int DIST_OUT_W = 33;
    localparam int TAN_W     = 16;

    typedef logic [OP_W-1:0]       t_op;
    typedef logic [IN_COORD_W-1:0] t_in_coord;
    typedef logic [START_W-1:0]    t_start;
    typedef logic [DIR_W-1:0]      t_dir;
    typedef logic [IDX_OUT_W-1:0]  t_idx_out;
    typedef logic [DIST_OUT_W-1:0] t_dist_out;
    typedef logic [TAN_W-1:0]      t_tan;

    // cone tangent after reset, about tan 5 degrees in Q0.16
    localparam t_tan CONE_TAN_RESET = t_tan'(5734);

    // operation codes
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    // direction codes
    localparam t_dir DIR_PX = 2'd0;
    localparam t_dir DIR_MX = 2'd1;
    localparam t_dir DIR_PY = 2'd2;
    localparam t_dir DIR_MY = 2'd3;

    // sequencer to evaluator
    typedef struct packed {
        logic clr;
        logic vld;
    } t_eval_cmd;

    // evaluator to sequencer
    typedef struct packed {
        logic busy;
        logic have;
    } t_eval_stat;

endpackage

@@ hdl/dnps_ram.sv @@
// dnps_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dnps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dnps_eval.sv @@
// dnps_eval.sv
// pipelined cone test and nearest tracker, one table entry per cycle
// depends on dnps_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "directional_nearest_point_search_top_defines.svh"

module dnps_eval #(
    parameter int COORD_BITS = dnps_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dnps_pkg::t_eval_cmd   i_cmd,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [COORD_BITS-1:0] i_x0,
    input  logic [COORD_BITS-1:0] i_y0,
    input  dnps_pkg::t_dir        i_dir,
    input  dnps_pkg::t_tan        i_tan,
    output dnps_pkg::t_eval_stat  o_stat,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [2*COORD_BITS:0] o_best_dist
);

    localparam int CB   = COORD_BITS;
    localparam int PW   = CB + dnps_pkg::TAN_W;
    localparam int SQW  = 2 * CB;
    localparam int DW   = 2 * CB + 1;

    // stage 1 offsets
    logic signed [CB:0] dx, dy, along, ortho, ortho_abs;
    logic               along_pos, coinc;

    logic              r_s1_vld, n_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [CB-1:0]     r_s1_along, r_s1_cross;
    logic              r_s1_pos, r_s1_coinc;

    logic              r_s2_vld, n_s2_vld;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [PW-1:0]     r_s2_prod;
    logic [SQW-1:0]    r_s2_sq_a, r_s2_sq_c;
    logic [CB-1:0]     r_s2_cross;
    logic              r_s2_pos, r_s2_coinc;

    logic              r_s3_vld, n_s3_vld;
    logic [IDX_W-1:0]  r_s3_idx;
    logic              r_s3_qual;
    logic [DW-1:0]     r_s3_dist;

    logic              r_have, n_have;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [DW-1:0]     r_best_dist, n_best_dist;

    always_comb begin
        dx = $signed({1'b0, i_x}) - $signed({1'b0, i_x0});
        dy = $signed({1'b0, i_y}) - $signed({1'b0, i_y0});
        unique case (i_dir)
            dnps_pkg::DIR_PX: begin along = dx;  ortho = dy; end
            dnps_pkg::DIR_MX: begin along = -dx; ortho = dy; end
            dnps_pkg::DIR_PY: begin along = dy;  ortho = dx; end
            default:          begin along = -dy; ortho = dx; end
        endcase
        ortho_abs = ortho[CB] ? -ortho : ortho;
        along_pos = !along[CB] && (along != '0);
        // a point on top of the start point counts for plus x only
        coinc     = (i_dir == dnps_pkg::DIR_PX) && (dx == '0) && (dy == '0);
    end

    always_comb begin
        n_s1_vld = i_cmd.vld;
        n_s2_vld = r_s1_vld;
        n_s3_vld = r_s2_vld;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        priority if (i_cmd.clr) begin
            n_have      = 1'b0;
            n_best_idx  = '0;
            n_best_dist = '0;
        end else if (r_s3_vld && r_s3_qual && (!r_have || (r_s3_dist < r_best_dist))) begin
            // strict compare keeps the lowest index on a tie
            n_have      = 1'b1;
            n_best_idx  = r_s3_idx;
            n_best_dist = r_s3_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            r_s3_vld <= n_s3_vld;
            r_have   <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx    <= i_idx;
        r_s1_along  <= along[CB-1:0];
        r_s1_cross  <= ortho_abs[CB-1:0];
        r_s1_pos    <= along_pos;
        r_s1_coinc  <= coinc;

        r_s2_idx    <= r_s1_idx;
        r_s2_prod   <= PW'(r_s1_along) * PW'(i_tan);
        r_s2_sq_a   <= SQW'(r_s1_along) * SQW'(r_s1_along);
        r_s2_sq_c   <= SQW'(r_s1_cross) * SQW'(r_s1_cross);
        r_s2_cross  <= r_s1_cross;
        r_s2_pos    <= r_s1_pos;
        r_s2_coinc  <= r_s1_coinc;

        r_s3_idx    <= r_s2_idx;
        r_s3_qual   <= r_s2_coinc ||
                       (r_s2_pos && ({r_s2_cross, {dnps_pkg::TAN_W{1'b0}}} < r_s2_prod));
        r_s3_dist   <= DW'(r_s2_sq_a) + DW'(r_s2_sq_c);

        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
    end

    assign o_stat.busy = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_stat.have = r_have;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;

    // index 0 is never filled, so it can never be the winner
    `DNPS_ASSERT_IMP(a_best_not_zero, i_clk, i_rst_n, r_have, r_best_idx != '0, "winner at index 0")
    // a winner only appears from a qualifying entry leaving the last stage
    `DNPS_ASSERT_IMP(a_have_source, i_clk, i_rst_n, $rose(r_have), $past(r_s3_vld && r_s3_qual), "winner without qualifier")
    // clearing drops the previous winner
    `DNPS_ASSERT_NXT(a_clr_drops, i_clk, i_rst_n, i_cmd.clr, !r_have && (r_best_dist == '0), "clear left a winner")

endmodule

@@ hdl/directional_nearest_point_search_top.sv @@
// directional_nearest_point_search_top.sv
// top level: point table, scan sequencer, config register and result register
// depends on dnps_pkg, dnps_ram, dnps_eval and the assertion macro header
`timescale 1ns / 1ps
`include "directional_nearest_point_search_top_defines.svh"

// Keeps a table of 2-D points in one memory and answers directional nearest
// neighbor queries. A query reads the start entry, then sweeps entries
// 1 .. next_slot-1 through the single read port of the point memory at one
// entry per cycle, and drains the evaluation pipeline; its result enters the
// result register once the previous result has been taken. The input side
// stalls for the whole query. An entry qualifies when its offset along the
// chosen axis is positive and |cross| * 65536 < along * cone_tangent; a point
// equal to the start point qualifies for plus x only. The nearest qualifier
// wins, the lowest index on a tie. Appends past the last table slot are dropped.
// The cone tangent register may only be written while no query is running.
module directional_nearest_point_search_top #(
    parameter int TABLE_DEPTH = dnps_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = dnps_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dnps_pkg::t_op         i_operation,
    input  dnps_pkg::t_in_coord   i_point_x,
    input  dnps_pkg::t_in_coord   i_point_y,
    input  dnps_pkg::t_start      i_start_index,
    input  dnps_pkg::t_dir        i_direction,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output dnps_pkg::t_idx_out    o_neighbor_index,
    output dnps_pkg::t_dist_out   o_distance_squared,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  dnps_pkg::t_tan        i_cfg_cone_tangent
);

    localparam int CB  = COORD_BITS;
    localparam int AW  = $clog2(TABLE_DEPTH);       // table address
    localparam int NSW = $clog2(TABLE_DEPTH + 1);   // slot count, holds the depth
    localparam int CW  = (NSW > dnps_pkg::START_W) ? NSW : dnps_pkg::START_W;
    localparam int DW  = 2 * CB + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;   // start entry read issued
    localparam logic [2:0] ST_LATCH = 3'd2;   // start point on the read port
    localparam logic [2:0] ST_SCAN  = 3'd3;   // one table read per cycle
    localparam logic [2:0] ST_DRAIN = 3'd4;   // wait for the pipeline to empty
    localparam logic [2:0] ST_DONE  = 3'd5;   // hand result to output register

    logic [2:0]           r_state, n_state;
    logic [NSW-1:0]       r_next_slot, n_next_slot;
    dnps_pkg::t_tan       r_cone_tan, n_cone_tan;
    dnps_pkg::t_start     r_start, n_start;
    logic                 r_start_oob, n_start_oob;
    dnps_pkg::t_dir       r_dir, n_dir;
    logic [CB-1:0]        r_x0, n_x0, r_y0, n_y0;
    logic [NSW-1:0]       r_scan_idx, n_scan_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [NSW-1:0]       r_rd_idx, n_rd_idx;
    logic                 r_out_vld, n_out_vld;
    logic                 r_out_found, n_out_found;
    dnps_pkg::t_idx_out   r_out_idx, n_out_idx;
    dnps_pkg::t_dist_out  r_out_dist, n_out_dist;

    logic                 in_xfer;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [2*CB-1:0]      ram_wdata, ram_rdata;
    logic [CB-1:0]        rd_x, rd_y;

    dnps_pkg::t_eval_cmd  eval_cmd;
    dnps_pkg::t_eval_stat eval_stat;
    logic [NSW-1:0]       best_idx;
    logic [DW-1:0]        best_dist;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // append write goes straight from the input transfer
    assign ram_we    = in_xfer && (i_operation == dnps_pkg::OP_APPEND) &&
                       (r_next_slot < NSW'(TABLE_DEPTH));
    assign ram_waddr = r_next_slot[AW-1:0];
    assign ram_wdata = {CB'(i_point_y), CB'(i_point_x)};
    assign ram_raddr = (r_state == ST_FETCH) ? AW'(r_start) : r_scan_idx[AW-1:0];
    assign rd_x      = ram_rdata[CB-1:0];
    assign rd_y      = ram_rdata[2*CB-1:CB];

    dnps_ram #(
        .WIDTH (2 * CB),
        .DEPTH (TABLE_DEPTH)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign eval_cmd.clr = (r_state == ST_LATCH);
    assign eval_cmd.vld = r_rd_vld;

    dnps_eval #(
        .COORD_BITS (CB),
        .IDX_W      (NSW)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (eval_cmd),
        .i_idx       (r_rd_idx),
        .i_x         (rd_x),
        .i_y         (rd_y),
        .i_x0        (r_x0),
        .i_y0        (r_y0),
        .i_dir       (r_dir),
        .i_tan       (r_cone_tan),
        .o_stat      (eval_stat),
        .o_best_idx  (best_idx),
        .o_best_dist (best_dist)
    );

    always_comb begin
        n_state     = r_state;
        n_next_slot = r_next_slot;
        n_cone_tan  = r_cone_tan;
        n_start     = r_start;
        n_start_oob = r_start_oob;
        n_dir       = r_dir;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_scan_idx  = r_scan_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_scan_idx;
        n_out_vld   = r_out_vld && i_out_stall;   // result transfer frees it
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        n_out_dist  = r_out_dist;

        if (i_cfg_valid) begin
            n_cone_tan = i_cfg_cone_tangent;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (i_operation)
                        dnps_pkg::OP_CLEAR: begin
                            // contents stay in memory but are no longer swept
                            n_next_slot = NSW'(1);
                        end
                        dnps_pkg::OP_APPEND: begin
                            if (ram_we) begin
                                n_next_slot = r_next_slot + NSW'(1);
                            end
                        end
                        dnps_pkg::OP_QUERY: begin
                            n_start     = i_start_index;
                            n_start_oob = (CW'(i_start_index) >= CW'(TABLE_DEPTH));
                            n_dir       = i_direction;
                            n_state     = ST_FETCH;
                        end
                        default: begin
                            // unused code, no effect
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_LATCH;
            end
            ST_LATCH: begin
                // start index beyond the table reads as the origin
                n_x0       = r_start_oob ? '0 : rd_x;
                n_y0       = r_start_oob ? '0 : rd_y;
                n_scan_idx = NSW'(1);
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_scan_idx < r_next_slot) begin
                    // the start entry itself is skipped
                    n_rd_vld   = (CW'(r_scan_idx) != CW'(r_start));
                    n_scan_idx = r_scan_idx + NSW'(1);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !eval_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!(r_out_vld && i_out_stall)) begin
                    n_out_vld   = 1'b1;
                    n_out_found = eval_stat.have;
                    n_out_idx   = dnps_pkg::t_idx_out'(best_idx);
                    n_out_dist  = dnps_pkg::t_dist_out'(best_dist);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_slot <= NSW'(1);
            r_cone_tan  <= dnps_pkg::CONE_TAN_RESET;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_slot <= n_next_slot;
            r_cone_tan  <= n_cone_tan;
            r_rd_vld    <= n_rd_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_start_oob <= n_start_oob;
        r_dir       <= n_dir;
        r_x0        <= n_x0;
        r_y0        <= n_y0;
        r_scan_idx  <= n_scan_idx;
        r_rd_idx    <= n_rd_idx;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
        r_out_dist  <= n_out_dist;
    end

    assign o_out_valid        = r_out_vld;
    assign o_found            = r_out_found;
    assign o_neighbor_index   = r_out_idx;
    assign o_distance_squared = r_out_dist;

    // fill count stays within 1 .. depth
    `DNPS_ASSERT(a_slot_range, i_clk, i_rst_n, (r_next_slot != '0) && (r_next_slot <= NSW'(TABLE_DEPTH)), "next slot out of range")
    // the sweep never runs past the filled part of the table
    `DNPS_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_scan_idx <= r_next_slot, "scan past fill count")
    // a finished query lands in the result register and frees the input side
    `DNPS_ASSERT_NXT(a_done_hands_off, i_clk, i_rst_n, (r_state == ST_DONE) && !(r_out_vld && i_out_stall), r_out_vld && (r_state == ST_IDLE), "result not handed off")
    // a miss reports index and distance zero
    `DNPS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_out_vld && !r_out_found, (r_out_idx == '0) && (r_out_dist == '0), "miss with nonzero payload")

endmodule
